FILE: design/crcfsv_pkg.sv
// Package for the CRC-16 frame signer/verifier: payload structs, register
// indexes, status codes and the CRC helper functions.
// No dependencies.
`default_nettype none

package crcfsv_pkg;

   // Configuration port
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 16;

   localparam logic [CsrIndexW-1:0] CSR_POLYNOMIAL     = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_INITIAL_VALUE  = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_REFLECT_INPUT  = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_REFLECT_OUTPUT = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_FINAL_XOR      = 3'd4;

   // Register reset values
   localparam logic [15:0] POLYNOMIAL_RESET    = 16'h1021;
   localparam logic [15:0] INITIAL_VALUE_RESET = 16'hFFFF;
   localparam logic [15:0] FINAL_XOR_RESET     = 16'h0000;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_SHORT    = 2'd2;

   // Frame modes
   localparam logic MODE_SIGN   = 1'b0;
   localparam logic MODE_VERIFY = 1'b1;

   // Queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;
   localparam int QueueCntW  = 2;

   // Verify hold count saturates here
   localparam logic [1:0] HOLD_FULL = 2'd2;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [15:0] crc_value;
      logic [15:0] received_crc;
      logic [1:0]  status;
   } rsp_type;

   // One classified byte on its way from front to back
   typedef struct packed {
      logic       first;
      logic       mode;
      logic [7:0] data_byte;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic [15:0] polynomial;
      logic [15:0] initial_value;
      logic        reflect_input;
      logic        reflect_output;
      logic [15:0] final_xor;
   } cfg_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[k] = v[7-k];
      end
      return r;
   endfunction

   function automatic logic [15:0] rev16(input logic [15:0] v);
      logic [15:0] r;
      for (int k = 0; k < 16; k++) begin
         r[k] = v[15-k];
      end
      return r;
   endfunction

   // One byte through the CRC register, MSB-first, eight polynomial steps
   function automatic logic [15:0] crc_absorb(input logic [15:0] crc,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly,
                                              input logic        refl);
      logic [15:0] c;
      logic [7:0]  bb;
      bb = refl ? rev8(b) : b;
      c  = crc ^ {bb, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_finish(input logic [15:0] crc,
                                              input logic        refl,
                                              input logic [15:0] fxor);
      logic [15:0] c;
      c = refl ? rev16(crc) : crc;
      return c ^ fxor;
   endfunction

endpackage

`default_nettype wire

FILE: design/crcfsv_front.sv
// Front end: accepts frame bytes, tags the first byte of each frame and
// latches the frame mode. Depends on crcfsv_pkg.
`default_nettype none

module crcfsv_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire crcfsv_pkg::req_type req_payload,
   output logic                     push_valid,
   input  wire logic                push_full,
   output crcfsv_pkg::entry_type    push_entry
);
   import crcfsv_pkg::*;

   logic in_frame_ff, in_frame_in;
   logic mode_ff, mode_in;
   logic transfer;

   // Stall whenever the queue has no room
   assign req_stall  = push_full;
   assign transfer   = req_valid && !push_full;
   assign push_valid = transfer;

   // Classify the byte: frame start picks up the mode from func
   always_comb begin
      push_entry.first     = !in_frame_ff;
      push_entry.mode      = in_frame_ff ? mode_ff : req_payload.func;
      push_entry.data_byte = req_payload.data_byte;
      push_entry.last      = req_payload.last;
   end

   // Track frame boundaries
   always_comb begin
      in_frame_in = in_frame_ff;
      mode_in     = mode_ff;
      if (transfer) begin
         in_frame_in = !req_payload.last;
         mode_in     = push_entry.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         mode_ff     <= MODE_SIGN;
      end else begin
         in_frame_ff <= in_frame_in;
         mode_ff     <= mode_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/crcfsv_queue.sv
// Short queue of classified bytes between front and back.
// Depends on crcfsv_pkg.
`default_nettype none

module crcfsv_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire crcfsv_pkg::entry_type push_entry,
   output logic                       full,
   output logic                       pop_valid,
   input  wire logic                  pop_take,
   output crcfsv_pkg::entry_type      pop_entry
);
   import crcfsv_pkg::*;

   entry_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == QueueCntW'(QueueDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_take && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/crcfsv_back.sv
// Back end: runs the CRC update, the verify hold register and the result
// register. Depends on crcfsv_pkg.
`default_nettype none

module crcfsv_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crcfsv_pkg::cfg_type   cfg,
   input  wire logic                  pop_valid,
   output logic                       pop_take,
   input  wire crcfsv_pkg::entry_type pop_entry,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output crcfsv_pkg::rsp_type        rsp_payload
);
   import crcfsv_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [1:0]  seen_ff, seen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0] crc_base;
   logic [7:0]  held1_base;
   logic [1:0]  seen_base;
   logic [15:0] calc;
   logic        room;

   // Take an entry whenever the result register is free or draining
   assign room     = !rsp_valid_ff || !rsp_stall;
   assign pop_take = pop_valid && room;

   // Frame start reloads the running state
   always_comb begin
      crc_base   = pop_entry.first ? cfg.initial_value : crc_ff;
      held1_base = pop_entry.first ? 8'h00 : held1_ff;
      seen_base  = pop_entry.first ? 2'd0 : seen_ff;
   end

   // Absorb a byte: directly in sign mode, delayed by two in verify mode
   always_comb begin
      crc_in   = crc_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      seen_in  = seen_ff;
      if (pop_take) begin
         if (pop_entry.mode == MODE_SIGN) begin
            crc_in = crc_absorb(crc_base, pop_entry.data_byte, cfg.polynomial,
                                cfg.reflect_input);
         end else begin
            crc_in = (seen_base == HOLD_FULL)
                   ? crc_absorb(crc_base, held0_ff, cfg.polynomial, cfg.reflect_input)
                   : crc_base;
            held0_in = held1_base;
            held1_in = pop_entry.data_byte;
            seen_in  = (seen_base == HOLD_FULL) ? HOLD_FULL : seen_base + 2'd1;
         end
      end
   end

   assign calc = crc_finish(crc_in, cfg.reflect_output, cfg.final_xor);

   // Build the result at the last byte
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (pop_take && pop_entry.last) begin
         rsp_valid_in = 1'b1;
         if (pop_entry.mode == MODE_SIGN) begin
            rsp_in.crc_value    = calc;
            rsp_in.received_crc = 16'h0000;
            rsp_in.status       = STATUS_OK;
         end else if (seen_in != HOLD_FULL) begin
            rsp_in.crc_value    = 16'h0000;
            rsp_in.received_crc = 16'h0000;
            rsp_in.status       = STATUS_SHORT;
         end else begin
            rsp_in.crc_value    = calc;
            rsp_in.received_crc = {held1_in, held0_in};
            rsp_in.status       = (calc == {held1_in, held0_in}) ? STATUS_OK
                                                                  : STATUS_MISMATCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seen_ff      <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
      end
   end

   // Hold payload state
   always_ff @(posedge clock) begin
      crc_ff   <= crc_in;
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: design/crc16_frame_sign_verify.sv
// Top level of the CRC-16 frame signer/verifier: configuration registers,
// front end, queue and back end. Depends on crcfsv_pkg and its submodules.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_type: func, data_byte, last
//   rsp_      out        rsp_valid/rsp_stall   rsp_type: crc_value, received_crc, status
//   csr_      in         csr_wr_en             csr_index, csr_wr_data
//
// One byte per cycle sustained while rsp_stall is low; the eight-step CRC update
// of the back end is unrolled into combinational logic.
// A result passes through the queue and then the result register after its last byte transfers.
// Reset (synchronous) restores all configuration registers and empties the queue.
// The two-entry queue lets the front keep taking bytes while a result stalls, until it is full.
`default_nettype none

module crc16_frame_sign_verify (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire crcfsv_pkg::req_type                   req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output crcfsv_pkg::rsp_type                        rsp_payload,
   input  wire logic                                  csr_wr_en,
   input  wire logic [crcfsv_pkg::CsrIndexW-1:0]      csr_index,
   input  wire logic [crcfsv_pkg::CsrDataW-1:0]       csr_wr_data
);
   import crcfsv_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_full;
   entry_type push_entry;
   logic      pop_valid, pop_take;
   entry_type pop_entry;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POLYNOMIAL:     cfg_in.polynomial     = csr_wr_data;
            CSR_INITIAL_VALUE:  cfg_in.initial_value  = csr_wr_data;
            CSR_REFLECT_INPUT:  cfg_in.reflect_input  = csr_wr_data[0];
            CSR_REFLECT_OUTPUT: cfg_in.reflect_output = csr_wr_data[0];
            CSR_FINAL_XOR:      cfg_in.final_xor      = csr_wr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial     <= POLYNOMIAL_RESET;
         cfg_ff.initial_value  <= INITIAL_VALUE_RESET;
         cfg_ff.reflect_input  <= 1'b0;
         cfg_ff.reflect_output <= 1'b0;
         cfg_ff.final_xor      <= FINAL_XOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crcfsv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_full   (push_full),
      .push_entry  (push_entry)
   );

   crcfsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (push_full),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_entry  (pop_entry)
   );

   crcfsv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_take    (pop_take),
      .pop_entry   (pop_entry),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
